FILE: hw/rtl/swx_pkg.sv
// Package for the sliding window top-x frequency sum block.
// Holds shared widths and default parameter values; no dependencies.
package swx_pkg;
    localparam int WINDOW_MAX_DEF = 64;
    localparam int VALUE_BITS_DEF = 32;
    localparam int SAMPLE_BITS    = 32;
    localparam int SUM_BITS       = 38;
    localparam int CFG_BITS       = 7;
    localparam int CFG_IDX_BITS   = 1;
    localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_LEN = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_TOP_COUNT  = 1'd1;
endpackage

FILE: hw/rtl/swx_in_if.sv
// Request and result channel interfaces for the sliding window top-x frequency sum block.
// Depends on swx_pkg for the payload widths.
interface swx_in_if;
    import swx_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;
    logic                   start_req;
    modport source (output valid, sample, start_req, input ready);
    modport sink (input valid, sample, start_req, output ready);
endinterface

interface swx_out_if;
    import swx_pkg::*;
    logic                valid;
    logic                ready;
    logic [SUM_BITS-1:0] x_sum;
    modport source (output valid, x_sum, input ready);
    modport sink (input valid, x_sum, output ready);
endinterface

FILE: hw/rtl/sliding_window_top_x_frequency_sum_core.sv
// Top level of the sliding window top-x frequency sum block.
// Depends on swx_pkg and the channel interfaces in swx_in_if.sv.

// Each request stores its sample in a ring of WINDOW_MAX entries and, once the window holds
// window_len samples, rebuilds a table of distinct values and sums count times value over the
// top_count highest ranked entries. One shared compare unit walks the table a step at a time.
// The build pass looks up each window sample in the table; the ranking pass then scans the whole
// table once per entry summed, for at most min(top_count, distinct values) entries, and a finish
// step hands the sum to the output register. A request that does not fill the window gives no
// result. The block takes no new request while it works; a finished result waits in that register.
module sliding_window_top_x_frequency_sum_core #(
    parameter int WINDOW_MAX = swx_pkg::WINDOW_MAX_DEF,
    parameter int VALUE_BITS = swx_pkg::VALUE_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [swx_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [swx_pkg::CFG_BITS-1:0]        cfg_data,
    swx_in_if.sink                              in_ch,
    swx_out_if.source                           out_ch
);
    import swx_pkg::*;

    localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CW = $clog2(WINDOW_MAX + 1);
    localparam int KW = CW + VALUE_BITS;
    localparam logic [AW-1:0] LAST_SLOT = AW'(WINDOW_MAX - 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_B_RD  = 3'd1;
    localparam logic [2:0] ST_B_V   = 3'd2;
    localparam logic [2:0] ST_S_RD  = 3'd3;
    localparam logic [2:0] ST_S_CMP = 3'd4;
    localparam logic [2:0] ST_R_RD  = 3'd5;
    localparam logic [2:0] ST_R_CMP = 3'd6;
    localparam logic [2:0] ST_FIN   = 3'd7;

    logic [VALUE_BITS-1:0] win_mem [WINDOW_MAX];
    logic [VALUE_BITS-1:0] val_mem [WINDOW_MAX];
    logic [CW-1:0]         cnt_mem [WINDOW_MAX];
    logic [VALUE_BITS-1:0] win_q, val_q;
    logic [CW-1:0]         cnt_q;

    logic [2:0]            state_reg, state_next;
    logic [CFG_BITS-1:0]   wlen_reg, top_reg;
    logic [AW-1:0]         wp_reg, wp_next, slot_reg, slot_next;
    logic [CW-1:0]         fill_reg, fill_next, i_reg, i_next, j_reg, j_next;
    logic [CW-1:0]         used_reg, used_next, r_reg, r_next;
    logic [VALUE_BITS-1:0] v_reg, v_next;
    logic [KW-1:0]         best_reg, best_next, prev_reg, prev_next;
    logic                  have_reg, have_next, hprev_reg, hprev_next;
    logic [SUM_BITS-1:0]   sum_reg, sum_next, xs_reg;
    logic                  ov_reg;

    logic [CW-1:0]         eff_len;
    logic                  accept, load_out;
    logic                  win_we, ent_we;
    logic [AW-1:0]         win_wa, ent_wa, win_ra, ent_ra;
    logic [VALUE_BITS-1:0] win_wd, val_wd;
    logic [CW-1:0]         cnt_wd;
    logic [KW-1:0]         key;
    logic [KW-1:0]         prod;

    assign eff_len = (wlen_reg == '0) ? CW'(1) :
                     (int'(wlen_reg) >= WINDOW_MAX) ? CW'(WINDOW_MAX) : CW'(wlen_reg);
    assign in_ch.ready = (state_reg == ST_IDLE) && (!ov_reg || out_ch.ready);
    assign accept = in_ch.valid && in_ch.ready;
    assign load_out = (state_reg == ST_FIN) && (!ov_reg || out_ch.ready);
    assign out_ch.valid = ov_reg;
    assign out_ch.x_sum = xs_reg;
    assign key = {cnt_q, val_q};
    assign prod = KW'(best_reg[KW-1:VALUE_BITS]) * KW'(best_reg[VALUE_BITS-1:0]);

    always_comb
    begin
        state_next = state_reg;
        wp_next    = wp_reg;
        fill_next  = fill_reg;
        slot_next  = slot_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        used_next  = used_reg;
        r_next     = r_reg;
        v_next     = v_reg;
        best_next  = best_reg;
        prev_next  = prev_reg;
        have_next  = have_reg;
        hprev_next = hprev_reg;
        sum_next   = sum_reg;
        win_we     = 1'b0;
        win_wa     = wp_reg;
        win_wd     = in_ch.sample[VALUE_BITS-1:0];
        ent_we     = 1'b0;
        ent_wa     = AW'(used_reg);
        val_wd     = v_reg;
        cnt_wd     = CW'(1);
        win_ra     = slot_reg;
        ent_ra     = AW'(j_reg);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    win_we = 1'b1;
                    if (in_ch.start_req)
                    begin
                        win_wa    = '0;
                        slot_next = '0;
                        wp_next   = (WINDOW_MAX > 1) ? AW'(1) : '0;
                        fill_next = CW'(1);
                    end
                    else
                    begin
                        slot_next = wp_reg;
                        wp_next   = (wp_reg == LAST_SLOT) ? '0 : wp_reg + AW'(1);
                        if (int'(fill_reg) < WINDOW_MAX)
                        begin
                            fill_next = fill_reg + CW'(1);
                        end
                    end
                    i_next    = '0;
                    used_next = '0;
                    if (fill_next >= eff_len)
                    begin
                        state_next = ST_B_RD;
                    end
                end
            end
            ST_B_RD:
            begin
                state_next = ST_B_V;
            end
            ST_B_V:
            begin
                v_next     = win_q;
                j_next     = '0;
                state_next = ST_S_RD;
            end
            ST_S_RD:
            begin
                if (j_reg == used_reg)
                begin
                    ent_we    = 1'b1;
                    used_next = used_reg + CW'(1);
                end
                else
                begin
                    state_next = ST_S_CMP;
                end
            end
            ST_S_CMP:
            begin
                if (val_q == v_reg)
                begin
                    ent_we = 1'b1;
                    ent_wa = AW'(j_reg);
                    cnt_wd = cnt_q + CW'(1);
                end
                else
                begin
                    j_next     = j_reg + CW'(1);
                    state_next = ST_S_RD;
                end
            end
            ST_R_RD:
            begin
                if (j_reg == used_reg)
                begin
                    if (!have_reg)
                    begin
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        sum_next   = sum_reg + SUM_BITS'(prod);
                        prev_next  = best_reg;
                        hprev_next = 1'b1;
                        r_next     = r_reg + CW'(1);
                        j_next     = '0;
                        have_next  = 1'b0;
                        if (int'(r_next) == int'(top_reg) || r_next == used_reg)
                        begin
                            state_next = ST_FIN;
                        end
                    end
                end
                else
                begin
                    state_next = ST_R_CMP;
                end
            end
            ST_R_CMP:
            begin
                if ((!hprev_reg || key < prev_reg) && (!have_reg || key > best_reg))
                begin
                    best_next = key;
                    have_next = 1'b1;
                end
                j_next     = j_reg + CW'(1);
                state_next = ST_R_RD;
            end
            ST_FIN:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (ent_we && (state_reg == ST_S_RD || state_reg == ST_S_CMP))
        begin
            i_next    = i_reg + CW'(1);
            slot_next = (slot_reg == '0) ? LAST_SLOT : slot_reg - AW'(1);
            if (i_next == eff_len)
            begin
                r_next     = '0;
                j_next     = '0;
                have_next  = 1'b0;
                hprev_next = 1'b0;
                sum_next   = '0;
                state_next = (top_reg == '0) ? ST_FIN : ST_R_RD;
            end
            else
            begin
                state_next = ST_B_RD;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (win_we)
        begin
            win_mem[win_wa] <= win_wd;
        end
        if (ent_we)
        begin
            val_mem[ent_wa] <= val_wd;
            cnt_mem[ent_wa] <= cnt_wd;
        end
        win_q <= win_mem[win_ra];
        val_q <= val_mem[ent_ra];
        cnt_q <= cnt_mem[ent_ra];
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
        i_reg    <= i_next;
        j_reg    <= j_next;
        used_reg <= used_next;
        r_reg    <= r_next;
        v_reg    <= v_next;
        best_reg <= best_next;
        prev_reg <= prev_next;
        have_reg <= have_next;
        hprev_reg <= hprev_next;
        sum_reg  <= sum_next;
        if (load_out)
        begin
            xs_reg <= sum_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            wp_reg    <= '0;
            fill_reg  <= '0;
            wlen_reg  <= CFG_BITS'(1);
            top_reg   <= CFG_BITS'(1);
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            wp_reg    <= wp_next;
            fill_reg  <= fill_next;
            if (cfg_we && cfg_index == REG_WINDOW_LEN)
            begin
                wlen_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == REG_TOP_COUNT)
            begin
                top_reg <= cfg_data;
            end
            if (load_out)
            begin
                ov_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready |-> state_reg == ST_IDLE)
        else $error("ready outside idle");
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(fill_reg) <= WINDOW_MAX)
        else $error("fill level overflow");
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= eff_len || state_reg == ST_IDLE)
        else $error("table grew past window");
    a_load: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> ov_reg && state_reg == ST_IDLE)
        else $error("result not held after load");
`endif
endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for the sliding window top-x frequency sum block.
// Depends on swx_pkg, the channel interfaces and sliding_window_top_x_frequency_sum_core.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import swx_pkg::*;

    localparam int DEPTH = 64;

    typedef struct {
        bit                  set_cfg;
        logic [CFG_BITS-1:0] wlen;
        logic [CFG_BITS-1:0] tcount;
        logic [31:0]         sample;
        bit                  start;
        bit                  typed;
        logic [SUM_BITS-1:0] x_sum;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [CFG_BITS-1:0] cfg_data;

    swx_in_if  in_ch();
    swx_out_if out_ch();

    sliding_window_top_x_frequency_sum_core uut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_ch(in_ch.sink), .out_ch(out_ch.source)
    );

    logic [31:0]         ring [DEPTH];
    int                  ring_ptr;
    int                  ring_fill;
    logic [CFG_BITS-1:0] cur_wlen;
    logic [CFG_BITS-1:0] cur_tcount;
    logic [SUM_BITS-1:0] sum_queue [$];
    bit                  failed;
    bit                  idle_on;
    int                  stall_left;
    int                  sent;
    logic [31:0]         pool [8];

    stim_row_t directed_rows [] = '{
        '{0, 0, 0, 32'h0000_0000, 0, 1, 38'h0},
        '{0, 0, 0, 32'hFFFF_FFFF, 0, 1, 38'h0_FFFF_FFFF},
        '{0, 0, 0, 32'h5555_5555, 1, 1, 38'h0_5555_5555},
        '{0, 0, 0, 32'hAAAA_AAAA, 0, 1, 38'h0_AAAA_AAAA},
        '{1, 7'd3, 7'd2, 32'd7, 0, 0, 38'h0},
        '{0, 0, 0, 32'd7, 0, 0, 38'h0},
        '{0, 0, 0, 32'd9, 0, 0, 38'h0},
        '{0, 0, 0, 32'd9, 0, 0, 38'h0},
        '{0, 0, 0, 32'd4, 0, 0, 38'h0},
        '{0, 0, 0, 32'd4, 1, 0, 38'h0},
        '{0, 0, 0, 32'd6, 0, 0, 38'h0},
        '{0, 0, 0, 32'd2, 0, 0, 38'h0},
        '{0, 0, 0, 32'd3, 0, 0, 38'h0},
        '{1, 7'd0, 7'd0, 32'hFFFF_FFFF, 0, 1, 38'h0},
        '{0, 0, 0, 32'd12, 1, 1, 38'h0},
        '{1, 7'd2, 7'd127, 32'd5, 0, 0, 38'h0},
        '{0, 0, 0, 32'd8, 0, 0, 38'h0},
        '{0, 0, 0, 32'd8, 0, 0, 38'h0},
        '{1, 7'd127, 7'd127, 32'd1, 1, 0, 38'h0},
        '{0, 0, 0, 32'd2, 0, 0, 38'h0},
        '{0, 0, 0, 32'd3, 0, 0, 38'h0}
    };

    function automatic logic [SUM_BITS-1:0] predict_sum(input int len);
        logic [31:0] vals [DEPTH];
        int          cnts [DEPTH];
        bit          taken [DEPTH];
        int          used;
        int          best;
        int          slot;
        bit          found;
        logic [SUM_BITS-1:0] acc;
        used = 0;
        acc = '0;
        for (int i = 0; i < len; i++)
        begin
            slot = (ring_ptr + DEPTH - 1 - i) % DEPTH;
            found = 0;
            for (int j = 0; j < used; j++)
            begin
                if (!found && vals[j] == ring[slot])
                begin
                    cnts[j]++;
                    found = 1;
                end
            end
            if (!found)
            begin
                vals[used] = ring[slot];
                cnts[used] = 1;
                taken[used] = 0;
                used++;
            end
        end
        for (int r = 0; r < int'(cur_tcount) && r < used; r++)
        begin
            best = -1;
            for (int j = 0; j < used; j++)
            begin
                if (!taken[j] && (best < 0 || cnts[j] > cnts[best] ||
                    (cnts[j] == cnts[best] && vals[j] > vals[best])))
                    best = j;
            end
            taken[best] = 1;
            acc += SUM_BITS'(cnts[best]) * SUM_BITS'(vals[best]);
        end
        return acc;
    endfunction

    function automatic bit advance_window(input logic [31:0] s, input bit st);
        int len;
        if (st)
        begin
            ring_ptr = 0;
            ring_fill = 0;
        end
        ring[ring_ptr] = s;
        ring_ptr = (ring_ptr + 1) % DEPTH;
        if (ring_fill < DEPTH)
            ring_fill++;
        len = (cur_wlen < 1) ? 1 : (cur_wlen > DEPTH) ? DEPTH : int'(cur_wlen);
        return ring_fill >= len;
    endfunction

    task automatic wait_idle();
        while (sum_queue.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_config(input logic [CFG_BITS-1:0] wl, input logic [CFG_BITS-1:0] tc);
        in_ch.valid = 0;
        wait_idle();
        cfg_we = 1;
        cfg_index = REG_WINDOW_LEN;
        cfg_data = wl;
        @(negedge clk);
        cfg_index = REG_TOP_COUNT;
        cfg_data = tc;
        @(negedge clk);
        cfg_we = 0;
        cur_wlen = wl;
        cur_tcount = tc;
    endtask

    task automatic send_request(input logic [31:0] s, input bit st, input bit typed,
                                input logic [SUM_BITS-1:0] x);
        int gap;
        logic [SUM_BITS-1:0] exp_sum;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 13);
            in_ch.valid = 0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid = 1;
        in_ch.sample = s;
        in_ch.start_req = st;
        do
            @(posedge clk);
        while (!in_ch.ready);
        if (advance_window(s, st))
        begin
            exp_sum = typed ? x : predict_sum(cur_wlen < 1 ? 1 :
                                              cur_wlen > DEPTH ? DEPTH : cur_wlen);
            sum_queue = {sum_queue, exp_sum};
        end
        sent++;
        @(negedge clk);
    endtask

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #1000ms;
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        stall_left = 0;
        out_ch.ready = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                out_ch.ready = 0;
                stall_left--;
            end
            else if (idle_on && $urandom_range(0, 6) == 0)
            begin
                out_ch.ready = 0;
                stall_left = $urandom_range(0, 12);
            end
            else
                out_ch.ready = 1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (sum_queue.size() == 0)
            begin
                $display("%0t: unexpected x_sum, expected none, actual %0d", $realtime,
                         out_ch.x_sum);
                failed = 1;
            end
            else if (out_ch.x_sum !== sum_queue[0])
            begin
                $display("%0t: x_sum mismatch, expected %0d, actual %0d", $realtime,
                         sum_queue[0], out_ch.x_sum);
                failed = 1;
                void'(sum_queue.pop_front());
            end
            else
                void'(sum_queue.pop_front());
        end
    end

    initial
    begin
        int phase_items;
        int mode;
        logic [31:0] s;
        failed = 0;
        idle_on = 1;
        sent = 0;
        ring_ptr = 0;
        ring_fill = 0;
        cur_wlen = 1;
        cur_tcount = 1;
        rst_n = 0;
        cfg_we = 0;
        cfg_index = REG_WINDOW_LEN;
        cfg_data = '0;
        in_ch.valid = 0;
        in_ch.sample = '0;
        in_ch.start_req = 0;
        repeat (3) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].set_cfg)
                write_config(directed_rows[i].wlen, directed_rows[i].tcount);
            send_request(directed_rows[i].sample, directed_rows[i].start,
                         directed_rows[i].typed, directed_rows[i].x_sum);
        end

        for (int phase = 0; sent < 1000; phase++)
        begin
            case (phase)
                0: begin write_config(7'd64, 7'd64); mode = 0; phase_items = 80; end
                1: begin write_config(7'd127, 7'd127); mode = 1; phase_items = 70; end
                2: begin write_config(7'd64, 7'd1); mode = 2; phase_items = 66; end
                3: begin write_config(7'd0, 7'd0); mode = 1; phase_items = 20; end
                4: begin write_config(7'd5, 7'd127); mode = 0; phase_items = 40; end
                default:
                begin
                    write_config(7'($urandom_range(1, 8)), 7'($urandom_range(0, 9)));
                    mode = ($urandom_range(0, 3) == 0) ? 1 : 0;
                    phase_items = $urandom_range(30, 60);
                end
            endcase
            foreach (pool[k])
                pool[k] = (k == 0) ? 32'hFFFF_FFFF : (k == 1) ? 32'h0 :
                          (phase == 0 && k > 3) ? pool[k % 4] : $urandom;
            if (phase == 6)
                wait_idle();
            if (sent > 880)
                idle_on = 0;
            for (int n = 0; n < phase_items; n++)
            begin
                s = (mode == 2) ? 32'hFFFF_FFFF : (mode == 1) ? $urandom :
                    pool[$urandom_range(0, 7)];
                send_request(s, (mode != 2 && $urandom_range(0, 40) == 0), 0, '0);
            end
        end

        in_ch.valid = 0;
        while (sum_queue.size() != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);
        if (!failed)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

FILE: sliding_window_top_x_frequency_sum_core.f
hw/rtl/swx_pkg.sv
hw/rtl/swx_in_if.sv
hw/rtl/sliding_window_top_x_frequency_sum_core.sv
tb/sv/testbench.sv
